>>> hdl/sffd_pkg.sv
// Package for the stereo fractional feedback delay: payload structs, register
// indexes and the control struct of the shared multiply-accumulate unit.
// No dependencies.
`timescale 1ns / 1ps

package sffd_pkg;

    localparam int SAMPLE_W  = 24;
    localparam int COEF_W    = 18;
    localparam int WHOLE_W   = 13;
    localparam int FRAC_W    = 16;
    localparam int FB_W      = 16;
    localparam int GAIN_W    = 17;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 17;

    localparam logic [GAIN_W-1:0] UNITY = 17'd65536;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left_in;
        logic signed [SAMPLE_W-1:0] right_in;
    } sffd_in_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left_out;
        logic signed [SAMPLE_W-1:0] right_out;
    } sffd_out_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DELAY_WHOLE = 3'd0,
        CFG_DELAY_FRAC  = 3'd1,
        CFG_FEEDBACK    = 3'd2,
        CFG_WET_GAIN    = 3'd3,
        CFG_DRY_GAIN    = 3'd4
    } sffd_cfg_index_t;

    typedef struct packed {
        logic mul_en;
        logic acc_en;
        logic acc_load;
        logic fin_add;
    } sffd_mac_ctrl_t;

endpackage

>>> hdl/sffd_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module sffd_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> hdl/sffd_mac.sv
// Shared multiply-accumulate unit: registered signed product, accumulator with
// rounding bias on load, and a Q16 rounding, optional offset and 24-bit saturation.
// Depends on sffd_pkg.
`timescale 1ns / 1ps

module sffd_mac
    import sffd_pkg::*;
(
    input  logic                       aclk,
    input  sffd_mac_ctrl_t             ctrl,
    input  logic signed [SAMPLE_W-1:0] op_a,
    input  logic signed [COEF_W-1:0]   op_b,
    input  logic signed [SAMPLE_W-1:0] add_in,
    output logic signed [SAMPLE_W-1:0] result
);

    localparam int PROD_W = SAMPLE_W + COEF_W;
    localparam int ACC_W  = PROD_W + 2;
    localparam int Q_W    = ACC_W - 16;
    localparam int SUM_W  = Q_W + 1;
    localparam logic signed [ACC_W-1:0] ROUND_BIAS = ACC_W'(32768);

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  prod_ext;
    logic signed [SUM_W-1:0]  sum;
    logic signed [SUM_W-1:0]  add_ext;

    assign prod_ext = {{(ACC_W - PROD_W){prod_reg[PROD_W-1]}}, prod_reg};

    always_ff @(posedge aclk) begin
        if (ctrl.mul_en) begin
            prod_reg <= op_a * op_b;
        end
        if (ctrl.acc_en) begin
            if (ctrl.acc_load) begin
                acc_reg <= prod_ext + ROUND_BIAS;
            end else begin
                acc_reg <= acc_reg + prod_ext;
            end
        end
    end

    always_comb begin
        add_ext = ctrl.fin_add ? {{(SUM_W - SAMPLE_W){add_in[SAMPLE_W-1]}}, add_in} : '0;
        sum     = {acc_reg[ACC_W-1], acc_reg[ACC_W-1:16]} + add_ext;
        if (sum[SUM_W-1:SAMPLE_W-1] == {(SUM_W - SAMPLE_W + 1){sum[SUM_W-1]}}) begin
            result = sum[SAMPLE_W-1:0];
        end else if (sum[SUM_W-1]) begin
            result = {1'b1, {(SAMPLE_W - 1){1'b0}}};
        end else begin
            result = {1'b0, {(SAMPLE_W - 1){1'b1}}};
        end
    end

endmodule

>>> hdl/stereo_fractional_feedback_delay_unit.sv
// Top level of the stereo fractional feedback delay with its sequencer.
// Depends on sffd_pkg, sffd_ram and sffd_mac.
//
// A stereo pair is taken as one beat on the s_ channel (s_valid, s_ready,
// s_data) and the mixed pair leaves as one beat on the m_ channel (m_valid,
// m_ready, m_data). Registers are written through cfg_wr_en, cfg_index and
// cfg_wdata, one per clock; the user must write them only while no pair is
// in flight, as the block itself does not enforce this. For each pair the
// delay-line read is issued with the input beat, then nine steps per channel
// run on the single shared 24 x 18 multiplier and its accumulator, and a
// write-back state writes both words back and registers the result beat. A
// new pair is taken only after the previous one has been written back.
// After reset the delay line is cleared one word a cycle, with s_ready low
// until every word is cleared. When the receiver stalls, the result is held
// in the output register; the next pair is still taken and computed, and then
// waits in the write-back cycle until the output register is free.
`timescale 1ns / 1ps

module stereo_fractional_feedback_delay_unit
    import sffd_pkg::*;
#(
    parameter int MAX_DELAY = 4096
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  sffd_in_t             s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output sffd_out_t            m_data,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_wdata
);

    localparam int AW     = $clog2(MAX_DELAY);
    localparam int PTR_W  = AW + 1;
    localparam int CMP_W  = (PTR_W > WHOLE_W) ? PTR_W : WHOLE_W;
    localparam int STEP_W = 4;
    localparam logic [STEP_W-1:0] LAST_STEP = 4'd8;

    typedef enum logic [3:0] {
        ST_CLEAR = 4'b0001,
        ST_IDLE  = 4'b0010,
        ST_CALC  = 4'b0100,
        ST_WRITE = 4'b1000
    } state_t;

    typedef enum logic [2:0] {
        MOP_A_NF,
        MOP_B_F,
        MOP_IP_FB,
        MOP_IN_DRY,
        MOP_IP_WET
    } mul_op_t;

    typedef enum logic [1:0] {
        FIN_NONE,
        FIN_IP,
        FIN_WR,
        FIN_OUT
    } fin_t;

    state_t                state_reg;
    logic [AW-1:0]         clr_reg;
    logic [STEP_W-1:0]     step_reg;
    logic                  chan_reg;
    logic [AW-1:0]         pos_reg;
    logic [AW-1:0]         pos_next;
    logic                  m_valid_reg;
    sffd_out_t             m_data_reg;
    sffd_in_t              in_reg;

    logic [WHOLE_W-1:0]    delay_whole_reg;
    logic [FRAC_W-1:0]     delay_frac_reg;
    logic [FB_W-1:0]       feedback_reg;
    logic [GAIN_W-1:0]     wet_gain_reg;
    logic [GAIN_W-1:0]     dry_gain_reg;

    logic signed [SAMPLE_W-1:0] prev_reg [2];
    logic signed [SAMPLE_W-1:0] wr_reg   [2];
    logic signed [SAMPLE_W-1:0] res_reg  [2];
    logic signed [SAMPLE_W-1:0] ip_reg;

    logic                  accept;
    logic                  out_free;
    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [2*SAMPLE_W-1:0] ram_wdata;
    logic [2*SAMPLE_W-1:0] ram_rdata;
    logic signed [SAMPLE_W-1:0] d_left;
    logic signed [SAMPLE_W-1:0] d_right;
    logic signed [SAMPLE_W-1:0] in_c;
    logic signed [SAMPLE_W-1:0] d_c;
    logic signed [SAMPLE_W-1:0] prev_c;
    logic                  whole_zero;
    logic [GAIN_W-1:0]     one_minus_f;
    logic [CMP_W-1:0]      whole_ext;
    logic [CMP_W-1:0]      max_ext;
    logic [CMP_W-1:0]      ring_len;
    logic [CMP_W-1:0]      pos_inc;

    sffd_mac_ctrl_t        mac_ctrl;
    mul_op_t               mul_op;
    fin_t                  fin;
    logic signed [SAMPLE_W-1:0] op_a;
    logic signed [COEF_W-1:0]   op_b;
    logic signed [SAMPLE_W-1:0] mac_result;

    assign accept   = s_valid && s_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delay_whole_reg <= 13'd100;
            delay_frac_reg  <= 16'd0;
            feedback_reg    <= 16'd58982;
            wet_gain_reg    <= 17'd32768;
            dry_gain_reg    <= 17'd32768;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_DELAY_WHOLE: delay_whole_reg <= cfg_wdata[WHOLE_W-1:0];
                CFG_DELAY_FRAC:  delay_frac_reg  <= cfg_wdata[FRAC_W-1:0];
                CFG_FEEDBACK:    feedback_reg    <= cfg_wdata[FB_W-1:0];
                CFG_WET_GAIN:    wet_gain_reg    <= cfg_wdata[GAIN_W-1:0];
                CFG_DRY_GAIN:    dry_gain_reg    <= cfg_wdata[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    // Ring position update.
    always_comb begin
        whole_ext = CMP_W'(delay_whole_reg);
        max_ext   = CMP_W'(MAX_DELAY);
        ring_len  = (whole_ext > max_ext) ? max_ext : whole_ext;
        pos_inc   = CMP_W'(pos_reg) + CMP_W'(1);
        pos_next  = (pos_inc >= ring_len) ? '0 : pos_inc[AW-1:0];
    end

    assign d_left  = ram_rdata[2*SAMPLE_W-1:SAMPLE_W];
    assign d_right = ram_rdata[SAMPLE_W-1:0];

    assign ram_we    = (state_reg == ST_CLEAR) || (state_reg == ST_WRITE && out_free);
    assign ram_waddr = (state_reg == ST_CLEAR) ? clr_reg : pos_reg;
    assign ram_wdata = (state_reg == ST_CLEAR) ? '0 : {wr_reg[0], wr_reg[1]};

    sffd_ram #(
        .WIDTH (2 * SAMPLE_W),
        .DEPTH (MAX_DELAY)
    ) u_line (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (accept),
        .raddr (pos_reg),
        .rdata (ram_rdata)
    );

    // Step schedule of one channel.
    always_comb begin
        mac_ctrl = '0;
        mul_op   = MOP_A_NF;
        fin      = FIN_NONE;
        if (state_reg == ST_CALC) begin
            unique case (step_reg)
                4'd0: begin
                    mac_ctrl.mul_en = 1'b1;
                    mul_op          = MOP_A_NF;
                end
                4'd1: begin
                    mac_ctrl.acc_en   = 1'b1;
                    mac_ctrl.acc_load = 1'b1;
                    mac_ctrl.mul_en   = 1'b1;
                    mul_op            = MOP_B_F;
                end
                4'd2: begin
                    mac_ctrl.acc_en = 1'b1;
                end
                4'd3: begin
                    fin = FIN_IP;
                end
                4'd4: begin
                    mac_ctrl.mul_en = 1'b1;
                    mul_op          = MOP_IP_FB;
                end
                4'd5: begin
                    mac_ctrl.acc_en   = 1'b1;
                    mac_ctrl.acc_load = 1'b1;
                    mac_ctrl.mul_en   = 1'b1;
                    mul_op            = MOP_IN_DRY;
                end
                4'd6: begin
                    fin               = FIN_WR;
                    mac_ctrl.fin_add  = 1'b1;
                    mac_ctrl.acc_en   = 1'b1;
                    mac_ctrl.acc_load = 1'b1;
                    mac_ctrl.mul_en   = 1'b1;
                    mul_op            = MOP_IP_WET;
                end
                4'd7: begin
                    mac_ctrl.acc_en = 1'b1;
                end
                4'd8: begin
                    fin = FIN_OUT;
                end
                default: ;
            endcase
        end
    end

    // Operand selection for the shared multiplier.
    always_comb begin
        in_c        = chan_reg ? in_reg.right_in : in_reg.left_in;
        d_c         = chan_reg ? d_right : d_left;
        prev_c      = prev_reg[chan_reg];
        whole_zero  = (delay_whole_reg == '0);
        one_minus_f = UNITY - {1'b0, delay_frac_reg};
        case (mul_op)
            MOP_A_NF: begin
                op_a = whole_zero ? in_c : d_c;
                op_b = $signed({1'b0, one_minus_f});
            end
            MOP_B_F: begin
                op_a = whole_zero ? d_c : prev_c;
                op_b = $signed({2'b00, delay_frac_reg});
            end
            MOP_IP_FB: begin
                op_a = ip_reg;
                op_b = $signed({2'b00, feedback_reg});
            end
            MOP_IN_DRY: begin
                op_a = in_c;
                op_b = $signed({1'b0, dry_gain_reg});
            end
            MOP_IP_WET: begin
                op_a = ip_reg;
                op_b = $signed({1'b0, wet_gain_reg});
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    sffd_mac u_mac (
        .aclk   (aclk),
        .ctrl   (mac_ctrl),
        .op_a   (op_a),
        .op_b   (op_b),
        .add_in (in_c),
        .result (mac_result)
    );

    // Sequencer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            step_reg    <= '0;
            chan_reg    <= 1'b0;
            pos_reg     <= '0;
            prev_reg[0] <= '0;
            prev_reg[1] <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && state_reg != ST_WRITE) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_CLEAR: begin
                    clr_reg <= clr_reg + AW'(1);
                    if (clr_reg == AW'(MAX_DELAY - 1)) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (s_valid) begin
                        state_reg <= ST_CALC;
                        step_reg  <= '0;
                        chan_reg  <= 1'b0;
                    end
                end
                ST_CALC: begin
                    if (step_reg == LAST_STEP) begin
                        step_reg <= '0;
                        if (chan_reg) begin
                            state_reg <= ST_WRITE;
                        end else begin
                            chan_reg <= 1'b1;
                        end
                    end else begin
                        step_reg <= step_reg + STEP_W'(1);
                    end
                end
                ST_WRITE: begin
                    if (out_free) begin
                        pos_reg     <= pos_next;
                        prev_reg[0] <= d_left;
                        prev_reg[1] <= d_right;
                        m_valid_reg <= 1'b1;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_CLEAR;
            endcase
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (accept) begin
            in_reg <= s_data;
        end
        case (fin)
            FIN_IP:  ip_reg            <= mac_result;
            FIN_WR:  wr_reg[chan_reg]  <= mac_result;
            FIN_OUT: res_reg[chan_reg] <= mac_result;
            default: ;
        endcase
        if (state_reg == ST_WRITE && out_free) begin
            m_data_reg.left_out  <= res_reg[0];
            m_data_reg.right_out <= res_reg[1];
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (state_reg == ST_CALC && step_reg == '0 && !chan_reg))
        else $error("Accepted pair did not start the left channel at the first step.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (PTR_W'(pos_reg) < PTR_W'(MAX_DELAY)))
        else $error("Write position outside the delay line.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_WRITE))
        else $error("Result beat raised outside the write-back cycle.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CALC) |-> (!ram_we && step_reg <= LAST_STEP))
        else $error("Delay line written or step out of range during calculation.");

endmodule

>>> bench/tb_stereo_fractional_feedback_delay_unit.sv
// Self-checking testbench for the stereo fractional feedback delay unit: directed and random
// stereo beats under random idling, checked against an in-bench comb filter predictor.
// Depends on sffd_pkg and stereo_fractional_feedback_delay_unit.
`timescale 1ns / 1ps

module tb_stereo_fractional_feedback_delay_unit;
    import sffd_pkg::*;

    localparam int MAX_DELAY     = 4096;
    localparam int SETTLE_CYCLES = 40;
    localparam int RANDOM_PHASES = 10;
    localparam int PHASE_BEATS   = 138;

    localparam logic signed [SAMPLE_W-1:0] PEAK_POS = 24'sh7FFFFF;
    localparam logic signed [SAMPLE_W-1:0] PEAK_NEG = 24'sh800000;
    localparam logic signed [SAMPLE_W-1:0] ZERO     = 24'sh000000;
    localparam logic signed [SAMPLE_W-1:0] MINUS1   = 24'shFFFFFF;
    localparam logic signed [SAMPLE_W-1:0] PLUS1    = 24'sh000001;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_valid   = 1'b0;
    logic                 s_ready;
    sffd_in_t             s_data    = '0;
    logic                 m_valid;
    logic                 m_ready   = 1'b0;
    sffd_out_t            m_data;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DAT_W-1:0] cfg_wdata = '0;

    stereo_fractional_feedback_delay_unit #(
        .MAX_DELAY(MAX_DELAY)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    logic [WHOLE_W-1:0] whole_reg = 13'd100;
    logic [FRAC_W-1:0]  frac_reg  = 16'd0;
    logic [FB_W-1:0]    fb_reg    = 16'd58982;
    logic [GAIN_W-1:0]  wet_reg   = 17'd32768;
    logic [GAIN_W-1:0]  dry_reg   = 17'd32768;

    logic signed [SAMPLE_W-1:0] line_mem [2][MAX_DELAY];
    logic signed [SAMPLE_W-1:0] last_read [2];
    int unsigned                wr_pos;

    sffd_in_t    pair_backlog[$];
    sffd_out_t   mix_expected[$];
    int unsigned mismatches = 0;
    bit          quiet      = 1'b0;
    int unsigned send_idle  = 0;
    int unsigned recv_stall = 0;

    function automatic longint round_q16(input longint v);
        return (v + 32768) >>> 16;
    endfunction

    function automatic longint clip24(input longint v);
        if (v > 8388607) return 8388607;
        if (v < -8388608) return -8388608;
        return v;
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] comb_channel(input int ch, input longint x,
                                                                input int unsigned pos);
        longint d, a, b, f, ip, fbv, wet, dry;
        d   = longint'(line_mem[ch][pos]);
        f   = longint'(frac_reg);
        fbv = longint'(fb_reg);
        wet = longint'(wet_reg);
        dry = longint'(dry_reg);
        // With no whole delay the fresh input takes the place of the older word.
        a = (whole_reg == 0) ? x : d;
        b = (whole_reg == 0) ? d : longint'(last_read[ch]);
        ip = clip24(round_q16(a * (65536 - f) + b * f));
        line_mem[ch][pos] = SAMPLE_W'(clip24(x + round_q16(fbv * ip)));
        last_read[ch] = SAMPLE_W'(d);
        return SAMPLE_W'(clip24(round_q16(x * dry + ip * wet)));
    endfunction

    function automatic sffd_out_t comb_step(input sffd_in_t beat);
        sffd_out_t   mix;
        int unsigned pos, ring;
        pos  = (wr_pos >= MAX_DELAY) ? 0 : wr_pos;
        ring = (whole_reg > MAX_DELAY) ? MAX_DELAY : whole_reg;
        mix.left_out  = comb_channel(0, longint'(beat.left_in), pos);
        mix.right_out = comb_channel(1, longint'(beat.right_in), pos);
        pos++;
        if (pos >= ring) pos = 0;
        wr_pos = pos;
        return mix;
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] random_sample();
        case ($urandom_range(0, 7))
            0: return PEAK_POS;
            1: return PEAK_NEG;
            2: return ZERO;
            3: return 24'($urandom_range(0, 511)) - 24'd256;
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic int unsigned pick_coef(input int unsigned top, input int unsigned typical);
        case ($urandom_range(0, 5))
            0: return 0;
            1: return top;
            default: return $urandom_range(0, typical);
        endcase
    endfunction

    function automatic int unsigned pick_whole(input int phase);
        case (phase)
            0: return 0;
            1: return 1;
            2: return 2;
            3: return $urandom_range(3, 16);
            4: return $urandom_range(17, 150);
            5: return MAX_DELAY;
            6: return $urandom_range(MAX_DELAY + 1, 8191);
            7: return $urandom_range(150, 1000);
            8: return $urandom_range(3, 40);
            default: return $urandom_range(1, 200);
        endcase
    endfunction

    task automatic write_reg(input sffd_cfg_index_t idx, input logic [31:0] value);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value[CFG_DAT_W-1:0];
        case (idx)
            CFG_DELAY_WHOLE: whole_reg = value[WHOLE_W-1:0];
            CFG_DELAY_FRAC:  frac_reg  = value[FRAC_W-1:0];
            CFG_FEEDBACK:    fb_reg    = value[FB_W-1:0];
            CFG_WET_GAIN:    wet_reg   = value[GAIN_W-1:0];
            CFG_DRY_GAIN:    dry_reg   = value[GAIN_W-1:0];
            default: ;
        endcase
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic configure(input int unsigned whole, input int unsigned frac,
                             input int unsigned fb, input int unsigned wet,
                             input int unsigned dry);
        write_reg(CFG_DELAY_WHOLE, whole);
        write_reg(CFG_DELAY_FRAC, frac);
        write_reg(CFG_FEEDBACK, fb);
        write_reg(CFG_WET_GAIN, wet);
        write_reg(CFG_DRY_GAIN, dry);
    endtask

    task automatic queue_pair(input logic signed [SAMPLE_W-1:0] left,
                              input logic signed [SAMPLE_W-1:0] right);
        sffd_in_t beat;
        beat.left_in  = left;
        beat.right_in = right;
        pair_backlog.push_back(beat);
    endtask

    task automatic settle();
        do @(negedge aclk);
        while (pair_backlog.size() != 0 || s_valid || mix_expected.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        @(negedge aclk);
    endtask

    initial begin
        forever #6 aclk = ~aclk;
    end

    initial begin
        #10_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid   <= 1'b0;
            s_data    <= '0;
            send_idle = 0;
        end else begin
            if (s_valid && s_ready) mix_expected.push_back(comb_step(s_data));
            if (!(s_valid && !s_ready)) begin
                if (send_idle > 0) begin
                    send_idle--;
                    s_valid <= 1'b0;
                end else if (pair_backlog.size() == 0) begin
                    s_valid <= 1'b0;
                end else if (!quiet && $urandom_range(0, 5) == 0) begin
                    send_idle = $urandom_range(0, 6);
                    s_valid <= 1'b0;
                end else begin
                    s_valid <= 1'b1;
                    s_data  <= pair_backlog.pop_front();
                end
            end
        end
    end

    always @(posedge aclk) begin
        sffd_out_t want;
        if (!aresetn) begin
            m_ready    <= 1'b0;
            recv_stall = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (mix_expected.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result beat, expected none, actual %0d / %0d",
                             $time, $signed(m_data.left_out), $signed(m_data.right_out));
                end else begin
                    want = mix_expected.pop_front();
                    if (m_data.left_out !== want.left_out) begin
                        mismatches++;
                        $display("%0t: left_out mismatch, expected %0d, actual %0d", $time,
                                 $signed(want.left_out), $signed(m_data.left_out));
                    end
                    if (m_data.right_out !== want.right_out) begin
                        mismatches++;
                        $display("%0t: right_out mismatch, expected %0d, actual %0d", $time,
                                 $signed(want.right_out), $signed(m_data.right_out));
                    end
                end
            end
            if (recv_stall > 0) begin
                recv_stall--;
                m_ready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                recv_stall = $urandom_range(0, 6);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin
        foreach (line_mem[c, i]) line_mem[c][i] = '0;
        last_read[0] = '0;
        last_read[1] = '0;
        wr_pos       = 0;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Register values from reset, with the sample extremes.
        queue_pair(PEAK_POS, PEAK_POS);
        queue_pair(PEAK_NEG, PEAK_NEG);
        queue_pair(ZERO, ZERO);
        queue_pair(MINUS1, PLUS1);
        queue_pair(PEAK_POS, PEAK_NEG);
        queue_pair(PEAK_NEG, PEAK_POS);
        settle();

        // No whole delay, full feedback and the largest gains, to drive the mix towards saturation.
        configure(0, 32768, 65535, 131071, 131071);
        queue_pair(PEAK_POS, PEAK_NEG);
        queue_pair(PEAK_NEG, PEAK_POS);
        queue_pair(ZERO, ZERO);
        queue_pair(PEAK_POS, PEAK_POS);
        queue_pair(PLUS1, MINUS1);
        settle();

        configure(1, 65535, 0, 65536, 0);
        queue_pair(PEAK_POS, MINUS1);
        queue_pair(PEAK_NEG, PLUS1);
        queue_pair(MINUS1, PEAK_POS);
        queue_pair(ZERO, PEAK_NEG);
        settle();

        // A whole delay above the ring size, then a ring shorter than the current position.
        configure(8191, 0, 64880, 0, 65536);
        queue_pair(PEAK_POS, PEAK_NEG);
        queue_pair(MINUS1, PLUS1);
        queue_pair(PEAK_NEG, PEAK_POS);
        queue_pair(PLUS1, ZERO);
        settle();

        write_reg(CFG_DELAY_WHOLE, 3);
        queue_pair(PEAK_POS, PEAK_POS);
        queue_pair(PEAK_NEG, MINUS1);
        queue_pair(ZERO, PEAK_POS);
        queue_pair(PLUS1, PEAK_NEG);
        settle();

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            if (phase == RANDOM_PHASES - 1) quiet = 1'b1;
            configure(pick_whole(phase), pick_coef(65535, 65535), pick_coef(65535, 64880),
                      pick_coef(131071, 65536), pick_coef(131071, 65536));
            repeat (PHASE_BEATS) queue_pair(random_sample(), random_sample());
            settle();
        end

        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

>>> sim.f
hdl/sffd_pkg.sv
hdl/sffd_ram.sv
hdl/sffd_mac.sv
hdl/stereo_fractional_feedback_delay_unit.sv
bench/tb_stereo_fractional_feedback_delay_unit.sv
